// ===== rtl/core/fts_pkg.sv =====
`timescale 1ns / 1ps

package fts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_TACH = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SWEEP_TICKS  = 2'd0,
    REG_WINDOW_TICKS = 2'd1,
    REG_RPM_FACTOR   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW = 10;

  localparam logic [7:0] SweepTicksRst  = 8'd100;
  localparam logic [7:0] WindowTicksRst = 8'd100;
  localparam logic [9:0] RpmFactorRst   = 10'd302;
  localparam logic [7:0] DutyRst        = 8'h80;
  localparam logic [1:0] AutoMaskRst    = 2'b11;
  localparam logic [1:0] LevelsRst      = 2'b11;

  typedef struct packed {
    logic [7:0] sweep_ticks;
    logic [7:0] window_ticks;
    logic [9:0] rpm_factor;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [15:0] rpm_a;
    logic [15:0] rpm_b;
    logic        report_fresh;
  } res_t;

endpackage

// ===== rtl/core/fts_core.sv =====
`timescale 1ns / 1ps

module fts_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fts_pkg::cfg_t cfg_i,
  input  logic         accept_i,
  input  logic [1:0]   cmd_i,
  input  logic         tach_a_level_i,
  input  logic         tach_b_level_i,
  input  logic [1:0]   auto_bits_i,
  input  logic [7:0]   duty_a_in_i,
  input  logic [7:0]   duty_b_in_i,
  output fts_pkg::res_t res_o
);
  import fts_pkg::*;

  logic [1:0]  auto_mask_q, auto_mask_d;
  logic [1:0]  levels_q, levels_d;
  logic [15:0] edges_a_q, edges_a_d, edges_b_q, edges_b_d;
  logic [7:0]  sweep_cnt_q, sweep_cnt_d, window_cnt_q, window_cnt_d;
  logic [7:0]  target_a_q, target_a_d, target_b_q, target_b_d;
  logic        rising_a_q, rising_a_d, rising_b_q, rising_b_d;
  logic [7:0]  applied_a_q, applied_a_d, applied_b_q, applied_b_d;
  logic [15:0] speed_a_q, speed_a_d, speed_b_q, speed_b_d;
  logic        fresh;
  cmd_e        cmd;
  logic [7:0]  sweep_inc, window_inc;
  logic [7:0]  step_a, step_b;
  logic        dir_a, dir_b;
  logic [25:0] prod_a, prod_b;
  logic [1:0]  changed;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign cmd        = cmd_e'(cmd_i);
  assign sweep_inc  = sat_inc8(sweep_cnt_q);
  assign window_inc = sat_inc8(window_cnt_q);
  assign step_a     = rising_a_q ? target_a_q + 8'd1 : target_a_q - 8'd1;
  assign step_b     = rising_b_q ? target_b_q + 8'd1 : target_b_q - 8'd1;
  // bounce at the ends; keep direction elsewhere
  assign dir_a = (step_a == 8'hFF) ? 1'b0 : (step_a == 8'h00) ? 1'b1 : rising_a_q;
  assign dir_b = (step_b == 8'hFF) ? 1'b0 : (step_b == 8'h00) ? 1'b1 : rising_b_q;
  assign prod_a  = edges_a_q * cfg_i.rpm_factor;
  assign prod_b  = edges_b_q * cfg_i.rpm_factor;
  assign changed = {tach_b_level_i, tach_a_level_i} ^ levels_q;

  always_comb begin
    auto_mask_d  = auto_mask_q;
    levels_d     = levels_q;
    edges_a_d    = edges_a_q;
    edges_b_d    = edges_b_q;
    sweep_cnt_d  = sweep_cnt_q;
    window_cnt_d = window_cnt_q;
    target_a_d   = target_a_q;
    target_b_d   = target_b_q;
    rising_a_d   = rising_a_q;
    rising_b_d   = rising_b_q;
    applied_a_d  = applied_a_q;
    applied_b_d  = applied_b_q;
    speed_a_d    = speed_a_q;
    speed_b_d    = speed_b_q;
    fresh        = 1'b0;
    if (accept_i) begin
      unique case (cmd)
        CMD_TICK: begin
          sweep_cnt_d  = sweep_inc;
          window_cnt_d = window_inc;
          if (sweep_inc >= cfg_i.sweep_ticks) begin
            if (auto_mask_q[0]) begin
              target_a_d = step_a;
              rising_a_d = dir_a;
            end
            if (auto_mask_q[1]) begin
              target_b_d = step_b;
              rising_b_d = dir_b;
            end
            applied_a_d = auto_mask_q[0] ? step_a : target_a_q;
            applied_b_d = auto_mask_q[1] ? step_b : target_b_q;
            sweep_cnt_d = '0;
          end
          if (window_inc >= cfg_i.window_ticks) begin
            speed_a_d    = prod_a[15:0];
            speed_b_d    = prod_b[15:0];
            edges_a_d    = '0;
            edges_b_d    = '0;
            window_cnt_d = '0;
            fresh        = 1'b1;
          end
        end
        CMD_TACH: begin
          if (changed[0]) edges_a_d = sat_inc16(edges_a_q);
          if (changed[1]) edges_b_d = sat_inc16(edges_b_q);
          levels_d = {tach_b_level_i, tach_a_level_i};
        end
        CMD_SET: begin
          auto_mask_d = auto_bits_i;
          if (auto_bits_i != 2'b00) window_cnt_d = '0;
          if (!auto_bits_i[0]) target_a_d = duty_a_in_i;
          if (!auto_bits_i[1]) target_b_d = duty_b_in_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.duty_a       = applied_a_d;
    res_o.duty_b       = applied_b_d;
    res_o.rpm_a        = speed_a_d;
    res_o.rpm_b        = speed_b_d;
    res_o.report_fresh = fresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_mask_q  <= AutoMaskRst;
      levels_q     <= LevelsRst;
      edges_a_q    <= '0;
      edges_b_q    <= '0;
      sweep_cnt_q  <= '0;
      window_cnt_q <= '0;
      target_a_q   <= DutyRst;
      target_b_q   <= DutyRst;
      rising_a_q   <= 1'b1;
      rising_b_q   <= 1'b1;
      applied_a_q  <= DutyRst;
      applied_b_q  <= DutyRst;
      speed_a_q    <= '0;
      speed_b_q    <= '0;
    end else begin
      auto_mask_q  <= auto_mask_d;
      levels_q     <= levels_d;
      edges_a_q    <= edges_a_d;
      edges_b_q    <= edges_b_d;
      sweep_cnt_q  <= sweep_cnt_d;
      window_cnt_q <= window_cnt_d;
      target_a_q   <= target_a_d;
      target_b_q   <= target_b_d;
      rising_a_q   <= rising_a_d;
      rising_b_q   <= rising_b_d;
      applied_a_q  <= applied_a_d;
      applied_b_q  <= applied_b_d;
      speed_a_q    <= speed_a_d;
      speed_b_q    <= speed_b_d;
    end
  end

  a_window_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh |=> (edges_a_q == '0 && edges_b_q == '0 && window_cnt_q == '0))
    else $error("window close did not clear edge counts");

  a_applied_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept_i && cmd == CMD_TICK) |=> ($stable(applied_a_q) && $stable(applied_b_q)))
    else $error("applied duty changed outside a tick");

  a_auto_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && cmd == CMD_SET && auto_bits_i != 2'b00) |=> window_cnt_q == '0)
    else $error("auto setting did not restart window");

  a_speed_only_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fresh |=> ($stable(speed_a_q) && $stable(speed_b_q)))
    else $error("speed changed without a window close");

endmodule

// ===== rtl/core/fts_out.sv =====
`timescale 1ns / 1ps

module fts_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fts_pkg::res_t res_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fts_pkg::res_t res_o
);
  import fts_pkg::*;

  logic valid_q, valid_d;
  logic load;
  res_t res_q;

  // take a new item when the slot is empty or being emptied this cycle
  assign in_stall_o = valid_q & out_stall_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/fan_tach_and_pwm_sweep.sv =====
`timescale 1ns / 1ps

// Two-fan tachometer and PWM sweep controller.
// Input channel (in_valid_i / in_stall_o): one item per handshake, cmd_i selects
// a timer tick, a tach pin sample or a host settings write; cmd 3 is a no-op.
// Output channel (out_valid_o / out_stall_i): exactly one item per input item,
// carrying the applied duties, the latched speeds and a window-closed flag.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 sweep ticks, 1 window
// ticks, 2 RPM factor; ready is always high, index 3 is ignored. Write only
// while no item is in flight.
// A result is registered and is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; state updates and the 16x10 speed multiply
// all fit in the accept cycle, and a single output register holds the result.
// When the receiver stalls, the output register holds its item and in_stall_o
// rises in the same cycle, so no item is lost or dropped.
// Reset: both fans in auto mode at duty 128 rising, counters and speeds zero,
// pin history high, registers at 100 / 100 / 302, output empty.
module fan_tach_and_pwm_sweep (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        tach_a_level_i,
  input  logic        tach_b_level_i,
  input  logic [1:0]  auto_bits_i,
  input  logic [7:0]  duty_a_in_i,
  input  logic [7:0]  duty_b_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  duty_a_o,
  output logic [7:0]  duty_b_o,
  output logic [15:0] rpm_a_o,
  output logic [15:0] rpm_b_o,
  output logic        report_fresh_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [fts_pkg::CfgDataW-1:0] cfg_data_i
);
  import fts_pkg::*;

  cfg_t     cfg_q, cfg_d;
  res_t     core_res, out_res;
  logic     accept;
  reg_idx_e cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = reg_idx_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx)
        REG_SWEEP_TICKS:  cfg_d.sweep_ticks  = cfg_data_i[7:0];
        REG_WINDOW_TICKS: cfg_d.window_ticks = cfg_data_i[7:0];
        REG_RPM_FACTOR:   cfg_d.rpm_factor   = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sweep_ticks  <= SweepTicksRst;
      cfg_q.window_ticks <= WindowTicksRst;
      cfg_q.rpm_factor   <= RpmFactorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = in_valid_i & ~in_stall_o;

  fts_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .tach_a_level_i (tach_a_level_i),
    .tach_b_level_i (tach_b_level_i),
    .auto_bits_i    (auto_bits_i),
    .duty_a_in_i    (duty_a_in_i),
    .duty_b_in_i    (duty_b_in_i),
    .res_o          (core_res)
  );

  fts_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_i       (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign duty_a_o       = out_res.duty_a;
  assign duty_b_o       = out_res.duty_b;
  assign rpm_a_o        = out_res.rpm_a;
  assign rpm_b_o        = out_res.rpm_b;
  assign report_fresh_o = out_res.report_fresh;

endmodule

// ===== test/fts_result_checker.sv =====
`timescale 1ns / 1ps

module fts_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        cmd_i,
  input  logic              tach_a_level_i,
  input  logic              tach_b_level_i,
  input  logic [1:0]        auto_bits_i,
  input  logic [7:0]        duty_a_in_i,
  input  logic [7:0]        duty_b_in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        duty_a_i,
  input  logic [7:0]        duty_b_i,
  input  logic [15:0]       rpm_a_i,
  input  logic [15:0]       rpm_b_i,
  input  logic              report_fresh_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       windows_o
);

  import fts_pkg::*;

  // Shadow registers and fan state; index 0 is fan A, index 1 is fan B.
  logic [7:0]  sweep_lim;
  logic [7:0]  window_lim;
  logic [9:0]  rate_mult;
  logic [1:0]  mode_auto;
  logic [1:0]  pin_last;
  logic [7:0]  sweep_cnt;
  logic [7:0]  window_cnt;
  logic [15:0] edge_cnt [2];
  logic [7:0]  duty_tgt [2];
  logic        duty_up  [2];
  logic [7:0]  duty_out [2];
  logic [15:0] speed    [2];

  res_t expected_q [$];
  res_t want;

  function automatic res_t predict_fan_status(cmd_e cmd, logic [1:0] pins,
                                              logic [1:0] auto_bits,
                                              logic [7:0] man_a, logic [7:0] man_b);
    res_t        r;
    logic [1:0]  moved;
    logic [25:0] prod;
    r.report_fresh = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (sweep_cnt != 8'hFF) sweep_cnt = sweep_cnt + 8'd1;
        if (window_cnt != 8'hFF) window_cnt = window_cnt + 8'd1;
        if (sweep_cnt >= sweep_lim) begin
          for (int f = 0; f < 2; f++) begin
            if (mode_auto[f]) begin
              // bounce between the ends; a manual end value wraps once
              duty_tgt[f] = duty_up[f] ? duty_tgt[f] + 8'd1 : duty_tgt[f] - 8'd1;
              if (duty_tgt[f] == 8'hFF) duty_up[f] = 1'b0;
              else if (duty_tgt[f] == 8'h00) duty_up[f] = 1'b1;
            end
            duty_out[f] = duty_tgt[f];
          end
          sweep_cnt = 8'd0;
        end
        if (window_cnt >= window_lim) begin
          for (int f = 0; f < 2; f++) begin
            prod = edge_cnt[f] * rate_mult;
            speed[f] = prod[15:0];
            edge_cnt[f] = 16'd0;
          end
          window_cnt = 8'd0;
          r.report_fresh = 1'b1;
        end
      end
      CMD_TACH: begin
        moved = pins ^ pin_last;
        for (int f = 0; f < 2; f++) begin
          if (moved[f] && edge_cnt[f] != 16'hFFFF) edge_cnt[f] = edge_cnt[f] + 16'd1;
        end
        pin_last = pins;
      end
      CMD_SET: begin
        mode_auto = auto_bits;
        if (auto_bits != 2'b00) window_cnt = 8'd0;
        if (!auto_bits[0]) duty_tgt[0] = man_a;
        if (!auto_bits[1]) duty_tgt[1] = man_b;
      end
      default: ;
    endcase
    r.duty_a = duty_out[0];
    r.duty_b = duty_out[1];
    r.rpm_a  = speed[0];
    r.rpm_b  = speed[1];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    if (errors_o < 40) begin
      $display("%0t: %s got %0h want %0h (result %0d)", $realtime, what, got, exp_val,
               checked_o);
    end
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_lim  <= SweepTicksRst;
      window_lim <= WindowTicksRst;
      rate_mult  <= RpmFactorRst;
      mode_auto  <= AutoMaskRst;
      pin_last   <= LevelsRst;
      sweep_cnt  <= 8'd0;
      window_cnt <= 8'd0;
      for (int f = 0; f < 2; f++) begin
        edge_cnt[f] <= 16'd0;
        duty_tgt[f] <= DutyRst;
        duty_up[f]  <= 1'b1;
        duty_out[f] <= DutyRst;
        speed[f]    <= 16'd0;
      end
      expected_q.delete();
      errors_o  <= 0;
      checked_o <= 0;
      windows_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_SWEEP_TICKS:  sweep_lim  = cfg_data_i[7:0];
          REG_WINDOW_TICKS: window_lim = cfg_data_i[7:0];
          REG_RPM_FACTOR:   rate_mult  = cfg_data_i;
          default: ;
        endcase
      end
      // retire before accepting: this edge's result belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item pending", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (duty_a_i !== want.duty_a) report_mismatch("duty_a", duty_a_i, want.duty_a);
          if (duty_b_i !== want.duty_b) report_mismatch("duty_b", duty_b_i, want.duty_b);
          if (rpm_a_i !== want.rpm_a) report_mismatch("rpm_a", rpm_a_i, want.rpm_a);
          if (rpm_b_i !== want.rpm_b) report_mismatch("rpm_b", rpm_b_i, want.rpm_b);
          if (report_fresh_i !== want.report_fresh) begin
            report_mismatch("report_fresh", report_fresh_i, want.report_fresh);
          end
          if (want.report_fresh) windows_o++;
        end
        checked_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_fan_status(cmd_e'(cmd_i),
                                                {tach_b_level_i, tach_a_level_i},
                                                auto_bits_i, duty_a_in_i, duty_b_in_i));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== test/fan_tach_and_pwm_sweep_test.sv =====
`timescale 1ns / 1ps

module fan_tach_and_pwm_sweep_test;

  import fts_pkg::*;

  localparam int unsigned LongHold    = 200;
  localparam int unsigned LongSamples = 80;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i          = 2'd0;
  logic        tach_a_level_i = 1'b1;
  logic        tach_b_level_i = 1'b1;
  logic [1:0]  auto_bits_i    = 2'd0;
  logic [7:0]  duty_a_in_i    = 8'd0;
  logic [7:0]  duty_b_in_i    = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  duty_a_o;
  logic [7:0]  duty_b_o;
  logic [15:0] rpm_a_o;
  logic [15:0] rpm_b_o;
  logic        report_fresh_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = 2'd0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned windows;

  bit          tx_steady     = 1'b1;
  bit          rx_steady     = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned items_sent    = 0;
  int unsigned reg_writes    = 0;

  always #5 clk_i = ~clk_i;

  fan_tach_and_pwm_sweep dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .tach_a_level_i (tach_a_level_i),
    .tach_b_level_i (tach_b_level_i),
    .auto_bits_i    (auto_bits_i),
    .duty_a_in_i    (duty_a_in_i),
    .duty_b_in_i    (duty_b_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_a_o       (duty_a_o),
    .duty_b_o       (duty_b_o),
    .rpm_a_o        (rpm_a_o),
    .rpm_b_o        (rpm_b_o),
    .report_fresh_o (report_fresh_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  fts_result_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .tach_a_level_i (tach_a_level_i),
    .tach_b_level_i (tach_b_level_i),
    .auto_bits_i    (auto_bits_i),
    .duty_a_in_i    (duty_a_in_i),
    .duty_b_in_i    (duty_b_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_a_i       (duty_a_o),
    .duty_b_i       (duty_b_o),
    .rpm_a_i        (rpm_a_o),
    .rpm_b_i        (rpm_b_o),
    .report_fresh_i (report_fresh_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .errors_o       (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .windows_o      (windows)
  );

  task automatic send_item(cmd_e cmd, logic tach_a, logic tach_b, logic [1:0] auto_bits,
                           logic [7:0] duty_a, logic [7:0] duty_b);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    tach_a_level_i <= tach_a;
    tach_b_level_i <= tach_b;
    auto_bits_i    <= auto_bits;
    duty_a_in_i    <= duty_a;
    duty_b_in_i    <= duty_b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_random();
    int unsigned pick;
    cmd_e        cmd;
    logic [7:0]  da;
    logic [7:0]  db;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_TACH;
    else if (pick < 85) cmd = CMD_TICK;
    else if (pick < 95) cmd = CMD_SET;
    else cmd = CMD_NONE;
    // favor the duty ends so the wrap cases come up often
    da = ($urandom_range(0, 3) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                     : 8'($urandom_range(0, 255));
    db = ($urandom_range(0, 3) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                     : 8'($urandom_range(0, 255));
    send_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), da, db);
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_random();
    end
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  // Receiver: random stall per result, plus long hold-offs on request.
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (holds_done != hold_requests) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        holds_done++;
      end else begin
        hold = rx_steady ? 0 : $urandom_range(0, 13);
        if (hold > 0) begin
          @(negedge clk_i) out_stall_i <= 1'b1;
          repeat (hold - 1) @(negedge clk_i);
        end
        @(negedge clk_i) out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  initial begin
    #10000000;
    $display("fan_tach_and_pwm_sweep: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: idle command, pin edges, ticks and a manual write
    send_item(CMD_NONE, 1'b1, 1'b1, 2'b11, 8'hFF, 8'hFF);
    send_item(CMD_TACH, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TACH, 1'b1, 1'b1, 2'b11, 8'hFF, 8'hFF);
    send_item(CMD_TACH, 1'b0, 1'b1, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TACH, 1'b1, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_SET,  1'b0, 1'b0, 2'b00, 8'hFF, 8'h00);
    send_item(CMD_TICK, 1'b1, 1'b1, 2'b11, 8'h00, 8'h00);
    wait_idle();
    write_reg(REG_SWEEP_TICKS, 10'd1);
    write_reg(REG_WINDOW_TICKS, 10'd2);
    write_reg(REG_RPM_FACTOR, 10'd1023);
    // manual 255 while rising, then back to auto: the step wraps to 0
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_SET,  1'b0, 1'b0, 2'b11, 8'h00, 8'hFF);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TACH, 1'b1, 1'b1, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TACH, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_SET,  1'b0, 1'b0, 2'b01, 8'h00, 8'd200);
    send_item(CMD_SET,  1'b0, 1'b0, 2'b10, 8'd7, 8'h00);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    wait_idle();
    // zero limits fire on every tick; the unused index changes nothing
    write_reg(REG_UNUSED, 10'h3FF);
    write_reg(REG_SWEEP_TICKS, 10'd0);
    write_reg(REG_WINDOW_TICKS, 10'd0);
    write_reg(REG_RPM_FACTOR, 10'd0);
    send_item(CMD_TACH, 1'b1, 1'b1, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    send_item(CMD_SET,  1'b0, 1'b0, 2'b00, 8'hFF, 8'hFF);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);

    for (int unsigned p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_SWEEP_TICKS, 10'd255);
          write_reg(REG_WINDOW_TICKS, 10'd255);
          write_reg(REG_RPM_FACTOR, 10'd1023);
        end
        1: begin
          write_reg(REG_SWEEP_TICKS, 10'd1);
          write_reg(REG_WINDOW_TICKS, 10'd1);
          write_reg(REG_RPM_FACTOR, 10'd1);
        end
        default: begin
          write_reg(REG_SWEEP_TICKS,
                    10'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16)));
          write_reg(REG_WINDOW_TICKS, 10'($urandom_range(1, 16)));
          write_reg(REG_RPM_FACTOR, 10'($urandom_range(0, 1023)));
        end
      endcase
      if (p == 2) begin
        // long receiver hold-off while items keep coming
        run_random(20);
        hold_requests++;
        run_random(70);
      end else if (p == 4) begin
        run_random(45);
        wait_idle();
        run_random(45);
      end else begin
        run_random(90);
      end
    end

    // pile up edges over a long window, then latch a count whose speed wraps
    wait_idle();
    write_reg(REG_WINDOW_TICKS, 10'd255);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int unsigned i = 0; i < LongSamples; i++) begin
      send_item(CMD_TACH, i[0], ~i[0], 2'b00, 8'h00, 8'h00);
    end
    wait_idle();
    write_reg(REG_WINDOW_TICKS, 10'd1);
    write_reg(REG_RPM_FACTOR, 10'd1023);
    send_item(CMD_TICK, 1'b0, 1'b0, 2'b00, 8'h00, 8'h00);
    run_random(40);

    wait_idle();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d items, checked %0d results, %0d speed windows closed.",
             items_sent, checked, windows);
    $display("%0d register writes: zero and max limits, long edge windows, stall pressure.",
             reg_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("fan_tach_and_pwm_sweep: match");
    end else begin
      $display("fan_tach_and_pwm_sweep: mismatch");
    end
    $finish;
  end

endmodule
